// ===== rtl/lfrb_pkg.sv =====
package lfrb_pkg;

  // Ring geometry. The ring holds 2**BufAw bytes, one slot is always kept empty.
  localparam int unsigned BufAw      = 12;
  localparam int unsigned BufBytes   = 1 << BufAw;
  localparam int unsigned LenW       = 13;
  localparam int unsigned MaxMessage = 4096;

  localparam logic [7:0] Newline = 8'h0A;

  localparam logic CmdPush = 1'b0;
  localparam logic CmdRead = 1'b1;

  typedef enum logic [2:0] {
    StStored  = 3'd0,
    StDropped = 3'd1,
    StNoLine  = 3'd2,
    StLineByte = 3'd3,
    StEndLine = 3'd4
  } status_e;

  typedef struct packed {
    logic             en;
    logic [BufAw-1:0] addr;
    logic [7:0]       data;
  } lfrb_wr_t;

  typedef struct packed {
    status_e    status;
    logic [7:0] line_byte;
  } lfrb_result_t;

endpackage

// ===== rtl/line_framed_byte_ring_buffer.sv =====
// Line-framed byte ring buffer. Every accepted word is a push of one message
// byte or a request for the next byte of a complete line, and every word
// yields exactly one result word, so the block sustains one word per clock
// while not stalled: the store has one write port and one read port, and
// the byte at the read head is always prefetched into a register so that a
// read decides from registered data alone. A message is admitted whole or
// not at all, judged on its first byte against the free space of the ring
// (which keeps one of its 4096 slots empty); its bytes and newlines become
// visible to readers only when its last byte arrives. A new first byte
// abandons any unfinished message. The result side has an output register
// plus a skid stage, so input keeps flowing while a result waits;
// in_stall_o rises only when both are full. The store needs no clearing pass
// after reset, since a read only ever reaches bytes that have been written.
module line_framed_byte_ring_buffer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic [7:0]  data_byte_i,
  input  logic        first_of_message_i,
  input  logic [12:0] msg_length_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [7:0]  line_byte_o
);

  localparam int unsigned Aw = lfrb_pkg::BufAw;
  localparam int unsigned Lw = lfrb_pkg::LenW;

  // Ring pointers and message bookkeeping.
  logic [Aw-1:0] read_head_q, read_head_d;
  logic [Aw-1:0] committed_head_q, committed_head_d;
  logic [Aw-1:0] pending_head_q, pending_head_d;
  logic [Lw-1:0] bytes_left_q, bytes_left_d;
  logic          accepting_q, accepting_d;
  logic [Aw-1:0] complete_lines_q, complete_lines_d;
  logic [Aw-1:0] pending_lines_q, pending_lines_d;

  // Output register and skid stage.
  logic                   out_valid_q, skid_valid_q;
  lfrb_pkg::lfrb_result_t out_q, skid_q, res;

  lfrb_pkg::lfrb_wr_t wr;
  logic [7:0]         head_byte;

  logic          accept;
  logic          out_held;
  logic [Aw-1:0] free_space;
  logic          st_en;
  logic [Aw-1:0] st_addr;
  logic [Lw-1:0] st_left;
  logic [Aw-1:0] st_lines;
  logic [Lw-1:0] left_after;
  logic [Aw-1:0] lines_after;
  logic [Aw-1:0] head_after;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_held = out_valid_q && out_stall_i;

  // With one empty slot kept, free space is (read - committed - 1) modulo the
  // ring size, which the pointer width gives for free.
  assign free_space = read_head_q - committed_head_q - Aw'(1);

  // Push path: pick the write position and counters to continue from. A
  // first byte restarts from the committed end.
  always_comb begin
    st_en    = 1'b0;
    st_addr  = pending_head_q;
    st_left  = bytes_left_q;
    st_lines = pending_lines_q;
    if (accept && (command_i == lfrb_pkg::CmdPush)) begin
      if (first_of_message_i) begin
        st_addr  = committed_head_q;
        st_left  = msg_length_i;
        st_lines = '0;
        st_en    = (msg_length_i != '0) &&
                   (msg_length_i <= Lw'(lfrb_pkg::MaxMessage)) &&
                   (msg_length_i <= {1'b0, free_space});
      end else begin
        st_en = accepting_q;
      end
    end
  end

  assign left_after  = st_left - Lw'(1);
  assign lines_after = st_lines + Aw'(data_byte_i == lfrb_pkg::Newline);
  assign head_after  = st_addr + Aw'(1);

  always_comb begin
    read_head_d      = read_head_q;
    committed_head_d = committed_head_q;
    pending_head_d   = pending_head_q;
    bytes_left_d     = bytes_left_q;
    accepting_d      = accepting_q;
    complete_lines_d = complete_lines_q;
    pending_lines_d  = pending_lines_q;
    res.status       = lfrb_pkg::StStored;
    res.line_byte    = '0;
    wr.en            = st_en;
    wr.addr          = st_addr;
    wr.data          = data_byte_i;

    if (accept) begin
      if (command_i == lfrb_pkg::CmdPush) begin
        if (first_of_message_i) begin
          // Abandon whatever was still being admitted.
          pending_head_d  = committed_head_q;
          pending_lines_d = '0;
          bytes_left_d    = '0;
          accepting_d     = 1'b0;
        end
        if (st_en) begin
          pending_head_d = head_after;
          if (left_after == '0) begin
            // Last byte: publish the whole message.
            committed_head_d = head_after;
            complete_lines_d = complete_lines_q + lines_after;
            pending_lines_d  = '0;
            bytes_left_d     = '0;
            accepting_d      = 1'b0;
          end else begin
            pending_lines_d = lines_after;
            bytes_left_d    = left_after;
            accepting_d     = 1'b1;
          end
        end else begin
          res.status = lfrb_pkg::StDropped;
        end
      end else begin
        if ((complete_lines_q == '0) || (read_head_q == committed_head_q)) begin
          res.status = lfrb_pkg::StNoLine;
        end else begin
          read_head_d = read_head_q + Aw'(1);
          if (head_byte == lfrb_pkg::Newline) begin
            complete_lines_d = complete_lines_q - Aw'(1);
            res.status       = lfrb_pkg::StEndLine;
          end else begin
            res.status    = lfrb_pkg::StLineByte;
            res.line_byte = head_byte;
          end
        end
      end
    end
  end

  // The store always reads at the next read head, so head_byte holds the
  // byte under read_head_q every cycle.
  lfrb_store u_store (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_addr_i (read_head_d),
    .rd_data_o (head_byte)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      read_head_q      <= '0;
      committed_head_q <= '0;
      pending_head_q   <= '0;
      bytes_left_q     <= '0;
      accepting_q      <= 1'b0;
      complete_lines_q <= '0;
      pending_lines_q  <= '0;
    end else begin
      read_head_q      <= read_head_d;
      committed_head_q <= committed_head_d;
      pending_head_q   <= pending_head_d;
      bytes_left_q     <= bytes_left_d;
      accepting_q      <= accepting_d;
      complete_lines_q <= complete_lines_d;
      pending_lines_q  <= pending_lines_d;
    end
  end

  // Result side. A new result goes to the skid stage only while the output
  // register is held; the skid drains into the output once it moves.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (accept) begin
      if (out_held) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (!out_held) begin
      out_valid_q  <= skid_valid_q;
      skid_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (out_held) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end else if (!out_held && skid_valid_q) begin
      out_q <= skid_q;
    end
  end

  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign status_o    = out_q.status;
  assign line_byte_o = out_q.line_byte;

  // An admitted message always has bytes still to come.
  a_accepting_has_bytes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accepting_q |-> (bytes_left_q != '0))
    else $error("message admitted with no bytes left");

  // Outside a message the pending side rests on the committed end.
  a_idle_pending_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accepting_q |-> (pending_head_q == committed_head_q) && (pending_lines_q == '0))
    else $error("pending state not cleared outside a message");

  // An empty visible region holds no newline.
  a_empty_no_lines : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (read_head_q == committed_head_q) |-> (complete_lines_q == '0))
    else $error("line count nonzero with nothing visible");

  // The skid stage fills only behind a held output.
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage full while output is empty");

  // A held result stays put while the skid stage takes the next one.
  a_out_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_held |=> $stable(out_q))
    else $error("held result changed");

endmodule

// ===== rtl/lfrb_store.sv =====
// Byte store with one write port and one registered read port. A write to
// the address being read in the same cycle is forwarded to the read data.
module lfrb_store (
  input  logic                         clk_i,
  input  lfrb_pkg::lfrb_wr_t           wr_i,
  input  logic [lfrb_pkg::BufAw-1:0]   rd_addr_i,
  output logic [7:0]                   rd_data_o
);

  logic [7:0] mem_q [lfrb_pkg::BufBytes];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en && (wr_i.addr == rd_addr_i)) begin
      rd_data_q <= wr_i.data;
    end else begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
